>>> hw/rtl/fid_pkg.sv
// shared types, constants and register codes of the fall and impact detector
package fid_pkg;

  localparam int MAG_FRAC_BITS = 8;
  localparam int TIME_W        = 32;
  localparam int MAG_W         = 12;
  localparam int STAB_W        = 3;
  localparam int MS_W          = 16;
  localparam int CODE_W        = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMPACT_THR = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FF_THR     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FF_CONFIRM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FF_MIN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_POST_STILL = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_COOLDOWN   = 3'd6;

  // register reset values
  localparam logic [MAG_W-1:0]  IMPACT_THR_RST = MAG_W'(3 << MAG_FRAC_BITS);
  localparam logic [MAG_W-1:0]  FF_THR_RST     = MAG_W'((2 << MAG_FRAC_BITS) / 10);
  localparam logic [MS_W-1:0]   FF_CONFIRM_RST = MS_W'(500);
  localparam logic [MS_W-1:0]   FF_MIN_RST     = MS_W'(100);
  localparam logic [MS_W-1:0]   POST_STILL_RST = MS_W'(2000);
  localparam logic [TIME_W-1:0] COOLDOWN_RST   = TIME_W'(30000);

  // fixed timing constants
  localparam logic [TIME_W-1:0] FREEFALL_TIMEOUT_MS = TIME_W'(1000);
  localparam logic [TIME_W-1:0] EARLY_MOTION_MS     = TIME_W'(500);
  localparam logic [TIME_W-1:0] POST_EXTRA_MS       = TIME_W'(2000);

  // stability classes
  localparam logic [STAB_W-1:0] STAB_UNKNOWN    = 3'd0;
  localparam logic [STAB_W-1:0] STAB_ON_TABLE   = 3'd1;
  localparam logic [STAB_W-1:0] STAB_STATIONARY = 3'd2;
  localparam logic [STAB_W-1:0] STAB_STABLE     = 3'd3;
  localparam logic [STAB_W-1:0] STAB_MOTION     = 3'd4;

  // event codes
  localparam logic [CODE_W-1:0] EV_IMPACT       = 2'd0;
  localparam logic [CODE_W-1:0] EV_FREEFALL     = 2'd1;
  localparam logic [CODE_W-1:0] EV_FALL_ALERT   = 2'd2;
  localparam logic [CODE_W-1:0] EV_IMPACT_ALERT = 2'd3;

  typedef struct packed {
    logic              detector_enable;
    logic [MAG_W-1:0]  impact_threshold;
    logic [MAG_W-1:0]  freefall_threshold;
    logic [MS_W-1:0]   ff_confirm_time;
    logic [MS_W-1:0]   freefall_min_ms;
    logic [MS_W-1:0]   still_time;
    logic [TIME_W-1:0] cooldown_time;
  } cfg_t;

  // one classified sample
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [MAG_W-1:0]  mag;
    logic              lowg;
    logic              motion;
    logic              still;
    logic              impact;
  } fid_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [MAG_W-1:0]  g;
  } fid_res_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_FREEFALL = 4'b0010,
    ST_IMPACT   = 4'b0100,
    ST_POST     = 4'b1000
  } state_t;

endpackage

>>> hw/rtl/fid_front.sv
// front stage: takes samples, drops them when disabled, classifies against thresholds
module fid_front import fid_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [MAG_W-1:0]   magnitude,
  input  logic [STAB_W-1:0]  stability,
  input  cfg_t               cfg,
  input  logic               q_full,
  output logic               q_push,
  output fid_item_t          q_item
);

  logic      item_valid;
  fid_item_t item;
  fid_item_t item_next;
  logic      accept;

  assign full   = item_valid && q_full;
  assign accept = push && !full;
  assign q_push = item_valid && !q_full;
  assign q_item = item;

  always_comb begin
    item_next.now_ms = now_ms;
    item_next.mag    = magnitude;
    item_next.lowg   = magnitude < cfg.freefall_threshold;
    item_next.motion = stability == STAB_MOTION;
    item_next.still  = (stability >= STAB_ON_TABLE) && (stability <= STAB_STABLE);
    item_next.impact = magnitude > cfg.impact_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= cfg.detector_enable;
    end else if (q_push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

>>> hw/rtl/fid_queue.sv
// two-entry queue of classified samples between front and back
module fid_queue import fid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  fid_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output fid_item_t pop_item
);

  fid_item_t   slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/fid_back.sv
// back stage: detection state machine, low-g timing, cooldown and result queue
module fid_back import fid_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  fid_item_t          q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [CODE_W-1:0]  event_code,
  output logic [MAG_W-1:0]   g_value
);

  state_t            state, state_next;
  logic [TIME_W-1:0] entry_time, entry_time_next;
  logic [MAG_W-1:0]  peak_g, peak_g_next;
  logic [TIME_W-1:0] lowg_start, lowg_start_next;
  logic              lowg_timing, lowg_timing_next;
  logic              freefall_ok, freefall_ok_next;
  logic [TIME_W-1:0] last_alert, last_alert_next;
  logic              alert_seen, alert_seen_next;

  fid_res_t          res_slot [2];
  logic              res_wr, res_rd;
  logic [1:0]        res_count;
  logic              res_valid;
  fid_res_t          res;
  logic              res_pop;

  logic              go;
  logic [TIME_W-1:0] dt, since_lowg, since_alert;
  logic              alert_req;
  logic [CODE_W-1:0] alert_code;
  logic              alert_ok;

  assign go      = !q_empty && (res_count != 2'd2);
  assign q_pop   = go;
  assign res_pop = pop && !empty;

  assign dt          = q_item.now_ms - entry_time;
  assign since_lowg  = q_item.now_ms - lowg_start;
  assign since_alert = q_item.now_ms - last_alert;
  assign alert_ok    = !(alert_seen && (since_alert < cfg.cooldown_time));

  always_comb begin
    state_next       = state;
    entry_time_next  = entry_time;
    peak_g_next      = peak_g;
    lowg_start_next  = lowg_start;
    lowg_timing_next = lowg_timing;
    freefall_ok_next = freefall_ok;
    last_alert_next  = last_alert;
    alert_seen_next  = alert_seen;
    res_valid        = 1'b0;
    res              = '0;
    alert_req        = 1'b0;
    alert_code       = EV_IMPACT_ALERT;
    if (go) begin
      if (q_item.mag > peak_g) peak_g_next = q_item.mag;

      // low-g timing only runs while in motion
      if (q_item.lowg && q_item.motion) begin
        if (!lowg_timing) begin
          lowg_start_next  = q_item.now_ms;
          lowg_timing_next = 1'b1;
        end else if (since_lowg >= TIME_W'(cfg.ff_confirm_time)) begin
          freefall_ok_next = 1'b1;
        end
      end else if (!q_item.lowg) begin
        lowg_timing_next = 1'b0;
        freefall_ok_next = 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_item.impact) begin
            state_next      = ST_IMPACT;
            entry_time_next = q_item.now_ms;
            peak_g_next     = q_item.mag;
            res_valid       = 1'b1;
            res.code        = EV_IMPACT;
            res.g           = q_item.mag;
          end else if (freefall_ok_next) begin
            state_next      = ST_FREEFALL;
            entry_time_next = q_item.now_ms;
            peak_g_next     = '0;
            res_valid       = 1'b1;
            res.code        = EV_FREEFALL;
            res.g           = q_item.mag;
          end
        end
        ST_FREEFALL: begin
          if (q_item.impact) begin
            state_next = (dt >= TIME_W'(cfg.freefall_min_ms)) ? ST_POST : ST_IMPACT;
            entry_time_next  = q_item.now_ms;
            peak_g_next      = q_item.mag;
            lowg_timing_next = 1'b0;
            freefall_ok_next = 1'b0;
          end else if (!q_item.lowg || (dt > FREEFALL_TIMEOUT_MS)) begin
            state_next       = ST_IDLE;
            peak_g_next      = '0;
            lowg_timing_next = 1'b0;
            freefall_ok_next = 1'b0;
          end
        end
        ST_IMPACT: begin
          state_next      = ST_POST;
          entry_time_next = q_item.now_ms;
        end
        ST_POST: begin
          if (dt >= TIME_W'(cfg.still_time)) begin
            alert_req  = 1'b1;
            alert_code = q_item.still ? EV_FALL_ALERT : EV_IMPACT_ALERT;
            state_next = ST_IDLE;
          end else if ((dt >= EARLY_MOTION_MS) && q_item.motion) begin
            alert_req  = 1'b1;
            alert_code = EV_IMPACT_ALERT;
            state_next = ST_IDLE;
          end else if (dt > (TIME_W'(cfg.still_time) + POST_EXTRA_MS)) begin
            // post-impact timeout, shadowed by the observation-time branch
            state_next  = ST_IDLE;
            peak_g_next = '0;
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase

      // alert inside cooldown is dropped and the peak kept
      if (alert_req && alert_ok) begin
        last_alert_next = q_item.now_ms;
        alert_seen_next = 1'b1;
        res_valid       = 1'b1;
        res.code        = alert_code;
        res.g           = peak_g_next;
        peak_g_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_time  <= '0;
      peak_g      <= '0;
      lowg_start  <= '0;
      lowg_timing <= 1'b0;
      freefall_ok <= 1'b0;
      last_alert  <= '0;
      alert_seen  <= 1'b0;
    end else begin
      state       <= state_next;
      entry_time  <= entry_time_next;
      peak_g      <= peak_g_next;
      lowg_start  <= lowg_start_next;
      lowg_timing <= lowg_timing_next;
      freefall_ok <= freefall_ok_next;
      last_alert  <= last_alert_next;
      alert_seen  <= alert_seen_next;
    end
  end

  // result queue
  assign empty      = res_count == 2'd0;
  assign event_code = res_slot[res_rd].code;
  assign g_value    = res_slot[res_rd].g;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_valid) res_wr <= !res_wr;
      if (res_pop) res_rd <= !res_rd;
      if (res_valid && !res_pop) begin
        res_count <= res_count + 2'd1;
      end else if (res_pop && !res_valid) begin
        res_count <= res_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_slot[res_wr] <= res;
    end
  end

endmodule

>>> hw/rtl/fall_impact_detector.sv
// top level of the fall and impact detector: config registers, front, queue and back
// Fall and impact detector. Each sample (millisecond timestamp, Q4.8 g magnitude and
// stability class) is pushed through a queue-like port and is accepted at one sample per
// clock cycle while full is low; results come out of a second queue as an event code and
// a Q4.8 g value, at most one per sample. A sample passes the classifying front register
// and the two-entry sample queue, whose head the update of the detection state machine
// reads while it writes the two-entry result queue. The state machine update sets the
// rate of one sample per cycle while the result queue is not full. With detector_enable
// low, samples are taken and dropped.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata; the user
// must write them only while no sample is in flight, which the block does not enforce;
// elapsed times wrap modulo 2^32.
module fall_impact_detector import fid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // sample side
  input  logic                  push,
  output logic                  full,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [MAG_W-1:0]      magnitude,
  input  logic [STAB_W-1:0]     stability,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output logic [CODE_W-1:0]     event_code,
  output logic [MAG_W-1:0]      g_value,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      q_push, q_full, q_pop, q_empty;
  fid_item_t q_in, q_out;

  // configuration registers, writes to unused indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detector_enable    <= 1'b0;
      cfg.impact_threshold   <= IMPACT_THR_RST;
      cfg.freefall_threshold <= FF_THR_RST;
      cfg.ff_confirm_time    <= FF_CONFIRM_RST;
      cfg.freefall_min_ms    <= FF_MIN_RST;
      cfg.still_time         <= POST_STILL_RST;
      cfg.cooldown_time      <= COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE:     cfg.detector_enable    <= cfg_wdata[0];
        CFG_IMPACT_THR: cfg.impact_threshold   <= cfg_wdata[MAG_W-1:0];
        CFG_FF_THR:     cfg.freefall_threshold <= cfg_wdata[MAG_W-1:0];
        CFG_FF_CONFIRM: cfg.ff_confirm_time    <= cfg_wdata[MS_W-1:0];
        CFG_FF_MIN:     cfg.freefall_min_ms    <= cfg_wdata[MS_W-1:0];
        CFG_POST_STILL: cfg.still_time         <= cfg_wdata[MS_W-1:0];
        CFG_COOLDOWN:   cfg.cooldown_time      <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // classify against thresholds, drop samples while disabled
  fid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .now_ms    (now_ms),
    .magnitude (magnitude),
    .stability (stability),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // lets the front keep taking samples while the back waits on the result side
  fid_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_out)
  );

  // state machine and result queue
  fid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .event_code (event_code),
    .g_value    (g_value)
  );

endmodule

>>> hw/rtl/fid_checker.sv
// port-level checks of the fall and impact detector, bound to the top level
module fid_checker import fid_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [CODE_W-1:0]     event_code,
  input logic [MAG_W-1:0]      g_value
);

  // both queues come out of reset drained
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // a waiting result never disappears without a pop transaction
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

  // a waiting result holds its payload
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(event_code) && $stable(g_value)))
    else $error("waiting result changed");

endmodule

bind fall_impact_detector fid_checker u_fid_checker (.*);

>>> tb/fall_impact_detector_tb.sv
// testbench of the fall and impact detector: directed and random samples against a predictor
`timescale 1ns / 100ps

module fall_impact_detector_tb;
  import fid_pkg::*;

  // clock, reset and block ports
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic [TIME_W-1:0]     now_ms;
  logic [MAG_W-1:0]      magnitude;
  logic [STAB_W-1:0]     stability;
  logic                  empty;
  logic                  pop;
  logic [CODE_W-1:0]     event_code;
  logic [MAG_W-1:0]      g_value;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fall_impact_detector uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .now_ms(now_ms), .magnitude(magnitude), .stability(stability),
    .empty(empty), .pop(pop),
    .event_code(event_code), .g_value(g_value),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // register copy and detector state of the predictor
  cfg_t              regs;
  state_t            fsm;
  logic [TIME_W-1:0] entry_t;
  logic [MAG_W-1:0]  peak;
  logic [TIME_W-1:0] lowg_t0;
  logic              lowg_on;
  logic              ff_ok;
  logic [TIME_W-1:0] last_alert_t;
  logic              alert_seen;

  // events still owed by the block, oldest first
  fid_res_t expected_events[$];
  int       errors = 0;

  // sample timeline and traffic shaping
  logic [TIME_W-1:0] ms;
  logic              steady = 1'b0;   // no idling on either side
  int                hold_len = 0;
  int                hold_id = 0;
  int                hold_seen = 0;
  int                hold_left = 0;

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] t_now,
                                                input logic [TIME_W-1:0] t_then);
    return t_now - t_then;
  endfunction

  task automatic queue_event(input logic [CODE_W-1:0] code, input logic [MAG_W-1:0] g);
    fid_res_t r;
    r.code = code;
    r.g    = g;
    expected_events.push_back(r);
  endtask

  // alert with cooldown; a dropped alert keeps the peak
  task automatic raise_alert(input logic [TIME_W-1:0] t, input logic [CODE_W-1:0] code);
    if (alert_seen && elapsed(t, last_alert_t) < regs.cooldown_time) return;
    last_alert_t = t;
    alert_seen   = 1'b1;
    queue_event(code, peak);
    peak = '0;
  endtask

  // one accepted sample through the detector
  task automatic update_detector(input logic [TIME_W-1:0] t, input logic [MAG_W-1:0] mag,
                                 input logic [STAB_W-1:0] stab);
    logic [TIME_W-1:0] dt;
    logic              still;
    if (!regs.detector_enable) return;
    if (mag > peak) peak = mag;

    // low-g timing only runs while in motion; a low-g sample at rest leaves it alone
    if (mag < regs.freefall_threshold && stab == STAB_MOTION) begin
      if (!lowg_on) begin
        lowg_t0 = t;
        lowg_on = 1'b1;
      end else if (elapsed(t, lowg_t0) >= TIME_W'(regs.ff_confirm_time)) begin
        ff_ok = 1'b1;
      end
    end else if (mag >= regs.freefall_threshold) begin
      lowg_on = 1'b0;
      ff_ok   = 1'b0;
    end

    dt = elapsed(t, entry_t);
    case (fsm)
      ST_IDLE: begin
        if (mag > regs.impact_threshold) begin
          fsm     = ST_IMPACT;
          entry_t = t;
          peak    = mag;
          queue_event(EV_IMPACT, mag);
        end else if (ff_ok) begin
          fsm     = ST_FREEFALL;
          entry_t = t;
          peak    = '0;
          queue_event(EV_FREEFALL, mag);
        end
      end
      ST_FREEFALL: begin
        if (mag > regs.impact_threshold) begin
          // a long enough freefall skips straight to observation
          fsm     = (dt >= TIME_W'(regs.freefall_min_ms)) ? ST_POST : ST_IMPACT;
          entry_t = t;
          peak    = mag;
          lowg_on = 1'b0;
          ff_ok   = 1'b0;
        end else if (mag >= regs.freefall_threshold || dt > FREEFALL_TIMEOUT_MS) begin
          fsm     = ST_IDLE;
          peak    = '0;
          lowg_on = 1'b0;
          ff_ok   = 1'b0;
        end
      end
      ST_IMPACT: begin
        fsm     = ST_POST;
        entry_t = t;
      end
      default: begin
        if (dt >= TIME_W'(regs.still_time)) begin
          // codes above stable count as not still
          still = (stab >= STAB_ON_TABLE) && (stab <= STAB_STABLE);
          raise_alert(t, still ? EV_FALL_ALERT : EV_IMPACT_ALERT);
          fsm = ST_IDLE;
        end else if (dt >= EARLY_MOTION_MS && stab == STAB_MOTION) begin
          raise_alert(t, EV_IMPACT_ALERT);
          fsm = ST_IDLE;
        end else if (dt > TIME_W'(regs.still_time) + POST_EXTRA_MS) begin
          // never reached, the observation branch comes first
          fsm  = ST_IDLE;
          peak = '0;
        end
      end
    endcase
  endtask

  // one sample transaction; push stays high after acceptance unless the next call idles
  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [MAG_W-1:0] mag,
                             input logic [STAB_W-1:0] stab);
    while (!steady && $urandom_range(0, 99) < 27) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    now_ms    <= t;
    magnitude <= mag;
    stability <= stab;
    @(posedge clk);
    while (full) @(posedge clk);
    update_detector(t, mag, stab);
  endtask

  // stop offering samples and let every owed event and in-flight sample clear
  task automatic drain_block();
    push <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // all seven registers in index order, with junk above each register narrower than the data word
  task automatic program_regs(input cfg_t c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ENABLE;
    cfg_wdata <= ($urandom() & ~32'h1) | 32'(c.detector_enable);
    @(posedge clk);
    cfg_addr  <= CFG_IMPACT_THR;
    cfg_wdata <= ($urandom() & ~32'hFFF) | 32'(c.impact_threshold);
    @(posedge clk);
    cfg_addr  <= CFG_FF_THR;
    cfg_wdata <= ($urandom() & ~32'hFFF) | 32'(c.freefall_threshold);
    @(posedge clk);
    cfg_addr  <= CFG_FF_CONFIRM;
    cfg_wdata <= ($urandom() & ~32'hFFFF) | 32'(c.ff_confirm_time);
    @(posedge clk);
    cfg_addr  <= CFG_FF_MIN;
    cfg_wdata <= ($urandom() & ~32'hFFFF) | 32'(c.freefall_min_ms);
    @(posedge clk);
    cfg_addr  <= CFG_POST_STILL;
    cfg_wdata <= ($urandom() & ~32'hFFFF) | 32'(c.still_time);
    @(posedge clk);
    cfg_addr  <= CFG_COOLDOWN;
    cfg_wdata <= c.cooldown_time;
    @(posedge clk);
    cfg_we    <= 1'b0;
    regs = c;
  endtask

  function automatic cfg_t make_cfg(input logic en, input int imp, input int ff,
                                    input int confirm, input int fmin, input int still,
                                    input logic [TIME_W-1:0] cooldown);
    cfg_t c;
    c.detector_enable    = en;
    c.impact_threshold   = MAG_W'(imp);
    c.freefall_threshold = MAG_W'(ff);
    c.ff_confirm_time    = MS_W'(confirm);
    c.freefall_min_ms    = MS_W'(fmin);
    c.still_time         = MS_W'(still);
    c.cooldown_time      = cooldown;
    return c;
  endfunction

  function automatic logic [MAG_W-1:0] lowg_mag();
    if (regs.freefall_threshold == 0) return '0;
    return MAG_W'($urandom_range(0, int'(regs.freefall_threshold) - 1));
  endfunction

  function automatic logic [MAG_W-1:0] impact_mag();
    if (regs.impact_threshold == 12'hFFF) return 12'hFFF;
    return MAG_W'($urandom_range(int'(regs.impact_threshold) + 1, 4095));
  endfunction

  // random episodes: mostly freefall-then-impact and plain impacts, the rest noise
  task automatic run_episodes(input int n_items);
    int sent;
    int kind;
    int k;
    int i;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if (kind < 4) begin
          // low-g run long enough to confirm, occasionally broken by a random class
          k = $urandom_range(2, 4);
          for (i = 0; i < k; i++) begin
            ms += int'(regs.ff_confirm_time) / (k - 1) + $urandom_range(0, 40);
            send_sample(ms, lowg_mag(),
                        ($urandom_range(0, 7) == 0) ? STAB_W'($urandom_range(0, 7))
                                                    : STAB_MOTION);
            sent++;
          end
          ms += $urandom_range(0, 2 * int'(regs.freefall_min_ms) + 60);
        end else begin
          ms += $urandom_range(1, 200);
        end
        send_sample(ms, impact_mag(), STAB_W'($urandom_range(0, 7)));
        sent++;
        // observation samples around the still time, any class
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) begin
          ms += int'(regs.still_time) / 2
                + $urandom_range(0, int'(regs.still_time) / 2 + 700);
          send_sample(ms, MAG_W'($urandom_range(0, 600)), STAB_W'($urandom_range(0, 7)));
          sent++;
        end
      end else begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 19) == 0) ms = $urandom();
          else ms += $urandom_range(0, 3000);
          send_sample(ms, MAG_W'($urandom_range(0, 4095)), STAB_W'($urandom_range(0, 7)));
          sent++;
        end
      end
      // sometimes let the cooldown run out so alerts get through
      if ($urandom_range(0, 2) == 0 && regs.cooldown_time < 32'd100000)
        ms += regs.cooldown_time;
    end
  endtask

  function automatic int pick_value(input int max_val, input int typical);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return max_val;
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset state: samples are dropped until the enable is set
  task automatic test_disabled();
    send_sample(32'd100, 12'hFFF, STAB_MOTION);
    send_sample(32'd200, 12'h000, STAB_MOTION);
    drain_block();
    program_regs(make_cfg(1'b1, int'(IMPACT_THR_RST), int'(FF_THR_RST), int'(FF_CONFIRM_RST),
                          int'(FF_MIN_RST), int'(POST_STILL_RST), COOLDOWN_RST));
  endtask

  // impact, observation, then a still class gives the first (never suppressed) fall alert
  task automatic test_impact_fall();
    send_sample(32'd1000, 12'hFFF, 3'd7);
    send_sample(32'd1010, 12'd300, STAB_MOTION);
    send_sample(32'd1500, 12'd256, STAB_MOTION);
    send_sample(32'd3010, 12'd256, STAB_STATIONARY);
  endtask

  // confirmed freefall with a resting low-g sample inside, then an alert lost to cooldown
  task automatic test_freefall_cooldown();
    send_sample(32'd5000, 12'd0, STAB_MOTION);
    send_sample(32'd5300, 12'd10, STAB_STATIONARY);
    send_sample(32'd5500, 12'd50, STAB_MOTION);
    send_sample(32'd5650, 12'd4000, STAB_MOTION);
    send_sample(32'd6200, 12'd200, STAB_MOTION);
  endtask

  // short freefall goes through the impact state; not-still classes give an impact alert
  task automatic test_short_freefall();
    send_sample(32'd40000, 12'd0, STAB_MOTION);
    send_sample(32'd40600, 12'd0, STAB_MOTION);
    send_sample(32'd40650, 12'd3000, 3'd5);
    send_sample(32'd40660, 12'd100, STAB_UNKNOWN);
    send_sample(32'd42660, 12'd100, 3'd7);
  endtask

  // freefall that lasts past its timeout falls back to idle
  task automatic test_freefall_timeout();
    send_sample(32'd50000, 12'd0, STAB_MOTION);
    send_sample(32'd50500, 12'd0, STAB_MOTION);
    send_sample(32'd51600, 12'd20, STAB_MOTION);
  endtask

  // elapsed time across the timestamp wrap
  task automatic test_time_wrap();
    send_sample(32'hFFFF_FF00, 12'hFFF, 3'd6);
    send_sample(32'hFFFF_FF10, 12'd0, STAB_STABLE);
    send_sample(32'h0000_0800, 12'd0, STAB_ON_TABLE);
    ms = 32'h0000_0800;
    drain_block();
  endtask

  task automatic test_default_rates();
    program_regs(make_cfg(1'b1, int'(IMPACT_THR_RST), int'(FF_THR_RST), int'(FF_CONFIRM_RST),
                          int'(FF_MIN_RST), int'(POST_STILL_RST), 32'd1000));
    run_episodes(200);
    drain_block();
  endtask

  // short times and no cooldown; receiver holds off while samples keep coming
  task automatic test_back_pressure();
    program_regs(make_cfg(1'b1, 768, 51, 60, 30, 300, 32'd0));
    steady   = 1'b1;
    hold_len = 300;
    hold_id++;
    run_episodes(220);
    steady = 1'b0;
    drain_block();
  endtask

  task automatic test_low_extremes();
    ms = $urandom();
    program_regs(make_cfg(1'b1, 0, 4095, 0, 0, 0, 32'd0));
    run_episodes(150);
    drain_block();
  endtask

  task automatic test_high_extremes();
    program_regs(make_cfg(1'b1, 4095, 4095, 65535, 65535, 65535, 32'hFFFF_FFFF));
    run_episodes(100);
    drain_block();
  endtask

  // random settings with the detector enabled, each other field at zero, its maximum or a typical value
  task automatic test_random_regs();
    int round;
    for (round = 0; round < 3; round++) begin
      program_regs(make_cfg(1'b1, pick_value(4095, 4095), pick_value(4095, 600),
                            pick_value(65535, 800), pick_value(65535, 300),
                            pick_value(65535, 3000),
                            ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                        : 32'($urandom_range(0, 5000))));
      run_episodes(70);
      drain_block();
    end
  endtask

  // disabled again with other settings: nothing must come out
  task automatic test_disabled_noise();
    program_regs(make_cfg(1'b0, 100, 2000, 10, 10, 10, 32'd0));
    run_episodes(30);
    drain_block();
  endtask

  // ---------------------------------------------------------------- result side

  task automatic check_event();
    fid_res_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: event expected none actual code %0d g_value %0d", $time, event_code,
               g_value);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    if (event_code !== want.code) begin
      $display("%0t: event_code expected %0d actual %0d", $time, want.code, event_code);
      errors++;
    end
    if (g_value !== want.g) begin
      $display("%0t: g_value expected %0d actual %0d", $time, want.g, g_value);
      errors++;
    end
  endtask

  // pops at random, all the time when steady, never during a requested hold-off
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) check_event();
      if (hold_id != hold_seen) begin
        hold_seen = hold_id;
        hold_left = hold_len;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    now_ms    <= '0;
    magnitude <= '0;
    stability <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_ENABLE;
    cfg_wdata <= '0;
    regs = make_cfg(1'b0, int'(IMPACT_THR_RST), int'(FF_THR_RST), int'(FF_CONFIRM_RST),
                    int'(FF_MIN_RST), int'(POST_STILL_RST), COOLDOWN_RST);
    fsm          = ST_IDLE;
    entry_t      = '0;
    peak         = '0;
    lowg_t0      = '0;
    lowg_on      = 1'b0;
    ff_ok        = 1'b0;
    last_alert_t = '0;
    alert_seen   = 1'b0;
    ms           = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_disabled();
    test_impact_fall();
    test_freefall_cooldown();
    test_short_freefall();
    test_freefall_timeout();
    test_time_wrap();
    test_default_rates();
    test_back_pressure();
    test_low_extremes();
    test_high_extremes();
    test_disabled_noise();
    test_random_regs();

    drain_block();
    if (errors == 0 && expected_events.size() == 0) begin
      $display("fall_impact_detector: match");
    end else begin
      $display("fall_impact_detector: mismatch");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("fall_impact_detector: mismatch");
    $finish;
  end

endmodule
